@@ src/vrc_pkg.sv @@
// Shared constants, types and helpers for the value rank compression block.
`default_nettype none

package vrc_pkg;

  localparam int MAX_COUNT = 64;
  localparam int ADDR_W    = $clog2(MAX_COUNT);
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int SAMPLE_W  = 32;
  localparam int RANK_W    = 6;

  // One classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [ADDR_W-1:0]   waddr;
    logic                keep;
    logic                final_item;
    logic [CNT_W-1:0]    count;
    logic                ovf;
  } vrc_entry_t;

  function automatic logic vrc_less(input logic [SAMPLE_W-1:0] a,
                                    input logic [SAMPLE_W-1:0] b);
    vrc_less = $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

@@ src/value_rank_compression.sv @@
// Top level of the value rank compression block: front end, queue, back end.
//
//   channel   ports                                   handshake
//   request   in_sample, in_final_item               start high while busy low
//   result    out_rank, out_run_end, out_overflowed  out_strobe, one cycle
//
// A non-final value leaves the queue as soon as the back end is idle.
// The last value of a run starts the rank sweep: for N stored values one
// buffer read port fetches the value being ranked, then visits every entry
// once per result, giving one result per stored value.
// Requests keep entering the two-entry queue during a sweep; busy rises when
// it is full. Synchronous reset empties the queue and clears the run count.
`default_nettype none

module value_rank_compression
  import vrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_final_item,
  output logic                     out_strobe,
  output logic [RANK_W-1:0]        out_rank,
  output logic                     out_run_end,
  output logic                     out_overflowed
);

  vrc_entry_t push_data;
  vrc_entry_t pop_data;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  vrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sample     (in_sample),
    .in_final_item (in_final_item),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  vrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  vrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (pop_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_strobe     (out_strobe),
    .out_rank       (out_rank),
    .out_run_end    (out_run_end),
    .out_overflowed (out_overflowed)
  );

endmodule

`default_nettype wire

@@ src/vrc_queue.sv @@
// Two-entry queue between the front end and the back end.
`default_nettype none

module vrc_queue
  import vrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire vrc_entry_t push_data,
  input  wire logic       pop,
  output vrc_entry_t      pop_data,
  output logic            full,
  output logic            empty
);

  vrc_entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       do_push, do_pop;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/vrc_front.sv @@
// Front end: accepts requests, assigns buffer slots and flags dropped values.
`default_nettype none

module vrc_front
  import vrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_final_item,
  input  wire logic                q_full,
  output logic                     q_push,
  output vrc_entry_t               q_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             keep;
  logic [CNT_W-1:0] count_after;
  logic             ovf_after;

  assign busy        = q_full;
  assign q_push      = start && !q_full;
  assign keep        = (count_r < CNT_W'(MAX_COUNT));
  assign count_after = keep ? count_r + CNT_W'(1) : count_r;
  assign ovf_after   = ovf_r | ~keep;

  always_comb begin
    q_data.sample     = in_sample;
    q_data.waddr      = count_r[ADDR_W-1:0];
    q_data.keep       = keep;
    q_data.final_item = in_final_item;
    q_data.count      = count_after;
    q_data.ovf        = ovf_after;
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (q_push) begin
      // drop the run bookkeeping once the last value is in
      count_nxt = in_final_item ? '0 : count_after;
      ovf_nxt   = in_final_item ? 1'b0 : ovf_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/vrc_back.sv @@
// Back end: value buffer and rank sweep emitting one result per stored value.
`default_nettype none

module vrc_back
  import vrc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire vrc_entry_t   q_data,
  input  wire logic         q_empty,
  output logic              q_pop,
  output logic              out_strobe,
  output logic [RANK_W-1:0] out_rank,
  output logic              out_run_end,
  output logic              out_overflowed
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_READK = 5'b00010,
    B_HOLDK = 5'b00100,
    B_SWEEP = 5'b01000,
    B_EMIT  = 5'b10000
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic [ADDR_W-1:0]   rank_r, rank_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [SAMPLE_W-1:0] vk_r, vk_nxt;
  logic [SAMPLE_W-1:0] mem [MAX_COUNT];
  logic [SAMPLE_W-1:0] rdata_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic                issue;
  logic                last_k;

  assign q_pop   = (state_r == B_IDLE) && !q_empty;
  assign wr_en   = q_pop && q_data.keep;
  assign issue   = (j_r < cnt_r);
  assign last_k  = ({1'b0, k_r} + CNT_W'(1)) == cnt_r;
  assign rd_addr = (state_r == B_READK) ? k_r : j_r[ADDR_W-1:0];

  assign out_strobe     = (state_r == B_EMIT);
  assign out_rank       = RANK_W'(rank_r);
  assign out_run_end    = last_k;
  assign out_overflowed = ovf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_data.waddr] <= q_data.sample;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    rank_nxt  = rank_r;
    cmp_v_nxt = cmp_v_r;
    vk_nxt    = vk_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop && q_data.final_item) begin
          cnt_nxt   = q_data.count;
          ovf_nxt   = q_data.ovf;
          k_nxt     = '0;
          state_nxt = B_READK;
        end
      end
      B_READK: begin
        state_nxt = B_HOLDK;
      end
      B_HOLDK: begin
        vk_nxt    = rdata_r;
        j_nxt     = '0;
        rank_nxt  = '0;
        cmp_v_nxt = 1'b0;
        state_nxt = B_SWEEP;
      end
      B_SWEEP: begin
        // read data arrives the cycle after its address
        if (issue) begin
          j_nxt = j_r + CNT_W'(1);
        end
        cmp_v_nxt = issue;
        if (cmp_v_r && vrc_less(rdata_r, vk_r)) begin
          rank_nxt = rank_r + ADDR_W'(1);
        end
        if (!issue && !cmp_v_r) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (last_k) begin
          state_nxt = B_IDLE;
        end else begin
          k_nxt     = k_r + ADDR_W'(1);
          state_nxt = B_READK;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ovf_r  <= ovf_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    rank_r <= rank_nxt;
    vk_r   <= vk_nxt;
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the value rank compression block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 410;
  localparam int DRAIN_CYCLES = 300;
  localparam int ROWS         = 19;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              run_end;
    logic              overflowed;
  } rank_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                final_item;
    logic                pinned;
    rank_result_t        result;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [SAMPLE_W-1:0] in_sample;
  logic                in_final_item;
  logic                out_strobe;
  logic [RANK_W-1:0]   out_rank;
  logic                out_run_end;
  logic                out_overflowed;

  // Predictor state: values of the open run and its drop flag.
  logic signed [SAMPLE_W-1:0] run_values [$];
  logic                       run_overflow;
  rank_result_t               rank_expect_q [$];

  bit           drive_pinned;
  rank_result_t pinned_result;
  int           error_count;
  int           cycle_count;

  // Rows 0-3: single-value runs, rank 0, last, none dropped; rest predicted.
  stim_row_t directed_rows [ROWS] = '{
    '{32'h8000_0000, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'h7fff_ffff, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'hffff_ffff, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'h7fff_ffff, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'hffff_ffff, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b1, 1'b0, '0},
    '{32'h1234_5678, 1'b0, 1'b0, '0},
    '{32'hedcb_a988, 1'b1, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b0, '0}
  };

  value_rank_compression i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_sample      (in_sample),
    .in_final_item  (in_final_item),
    .out_strobe     (out_strobe),
    .out_rank       (out_rank),
    .out_run_end    (out_run_end),
    .out_overflowed (out_overflowed)
  );

  always #5 clk = ~clk;

  // Store one value and, on the last of a run, queue a rank per stored value.
  function automatic void absorb_value(logic [SAMPLE_W-1:0] v, logic fin);
    int smaller;
    rank_result_t r;
    if (run_values.size() < MAX_COUNT) run_values.push_back(v);
    else run_overflow = 1'b1;
    if (!fin) return;
    foreach (run_values[k]) begin
      smaller = 0;
      foreach (run_values[j]) if (run_values[j] < run_values[k]) smaller++;
      r.rank       = smaller[RANK_W-1:0];
      r.run_end    = (k == run_values.size() - 1);
      r.overflowed = run_overflow;
      rank_expect_q.push_back(r);
    end
    run_values.delete();
    run_overflow = 1'b0;
  endfunction

  // Mix of wide random, clustered small and near-extreme values.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    if (sel < 8) return SAMPLE_W'($signed($urandom_range(8)) - 4);
    if (sel == 8) return 32'h8000_0000 + $urandom_range(3);
    return 32'h7fff_ffff - $urandom_range(3);
  endfunction

  task automatic send_value(input logic [SAMPLE_W-1:0] v, input logic fin, input bit pin,
                            input rank_result_t pin_r, input bit steady);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    drive_pinned  = pin;
    pinned_result = pin_r;
    start         <= 1'b1;
    in_sample     <= v;
    in_final_item <= fin;
    // hold the request until the block takes it
    do @(posedge clk); while (busy);
    @(negedge clk);
    drive_pinned = 1'b0;
  endtask

  always @(posedge clk) begin
    rank_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      if (out_strobe) begin
        if (rank_expect_q.size() == 0) begin
          $error("unexpected result: rank %0d run_end %0d overflowed %0d",
                 out_rank, out_run_end, out_overflowed);
          error_count++;
        end else begin
          want = rank_expect_q.pop_front();
          if (out_rank !== want.rank) begin
            $error("rank mismatch: expected %0d, got %0d", want.rank, out_rank);
            error_count++;
          end
          if (out_run_end !== want.run_end) begin
            $error("run_end mismatch: expected %0d, got %0d", want.run_end, out_run_end);
            error_count++;
          end
          if (out_overflowed !== want.overflowed) begin
            $error("overflowed mismatch: expected %0d, got %0d",
                   want.overflowed, out_overflowed);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        if (drive_pinned) begin
          run_values.delete();
          run_overflow = 1'b0;
          rank_expect_q.push_back(pinned_result);
        end else begin
          absorb_value(in_sample, in_final_item);
        end
      end
    end
  end

  initial begin
    int values_sent;
    int run_idx;
    int run_len;
    int full_lens [3];
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_sample     = '0;
    in_final_item = 1'b0;
    drive_pinned  = 1'b0;
    pinned_result = '0;
    run_overflow  = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    values_sent   = 0;
    run_idx       = 0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_value(directed_rows[i].sample, directed_rows[i].final_item,
                 directed_rows[i].pinned, directed_rows[i].result, 1'b0);

    // full buffer exactly, last value dropped, several values dropped
    full_lens = '{MAX_COUNT, MAX_COUNT + 1, MAX_COUNT + 6};
    foreach (full_lens[r]) begin
      for (int i = 0; i < full_lens[r]; i++)
        send_value(pick_sample(), i == full_lens[r] - 1, 1'b0, '0, 1'b0);
      values_sent += full_lens[r];
    end

    while (values_sent < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) run_len = $urandom_range(MAX_COUNT + 6, MAX_COUNT - 2);
      else run_len = $urandom_range(12, 1);
      for (int i = 0; i < run_len; i++)
        send_value(pick_sample(), i == run_len - 1, 1'b0, '0, run_idx inside {[6:14]});
      values_sent += run_len;
      run_idx++;
    end
    start <= 1'b0;

    while (rank_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
